// ----- rtl/button_click_classifier_macros.svh -----
// Assertion macros shared by the button click classifier RTL.
// Depends on clk_i and rst_ni being in scope where a macro is used.
`ifndef BUTTON_CLICK_CLASSIFIER_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BCC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bcc assertion failed");

// Next-cycle implication, checked outside reset.
`define BCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bcc assertion failed");

`endif

// ----- rtl/bcc_pkg.sv -----
// Types and constants of the button click classifier.
// No dependencies; used by every module of the block.
package bcc_pkg;

  typedef enum logic [2:0] {
    ST_OPEN     = 3'd0,
    ST_CLICKED  = 3'd1,
    ST_DOUBLE   = 3'd2,
    ST_HELD     = 3'd3,
    ST_RELEASED = 3'd4
  } status_e;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_READ = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    REG_ACTIVE_LEVEL = 2'd0,
    REG_HOLD_LIM     = 2'd1,
    REG_DCLICK_WIN   = 2'd2
  } reg_idx_e;

  localparam int unsigned CntW   = 9;
  localparam int unsigned TickW  = 8;
  localparam logic [CntW-1:0] CntMax = '1;

  typedef struct packed {
    action_e action;
    logic    pin_level;
  } item_t;

  typedef struct packed {
    logic             active_level;
    logic [TickW-1:0] hold_lim;
    logic [TickW-1:0] dclick_win;
  } cfg_t;

endpackage

// ----- rtl/bcc_state.sv -----
// Classifier state: pressed counter, double-click window timer and status.
// Depends on bcc_pkg.
module bcc_state
  import bcc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output status_e status_o
);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [TickW-1:0] tmr_q, tmr_d, tmr_mid;
  status_e          st_q, st_d, st_mid;

  always_comb begin
    cnt_d   = cnt_q;
    tmr_mid = tmr_q;
    st_mid  = st_q;
    tmr_d   = tmr_q;
    st_d    = st_q;
    if (item_i.action == ACT_TICK) begin
      if (item_i.pin_level == cfg_i.active_level) begin
        // saturate rather than wrap
        cnt_d = (cnt_q == CntMax) ? cnt_q : cnt_q + {{(CntW-1){1'b0}}, 1'b1};
        if (cnt_d > {1'b0, cfg_i.hold_lim}) begin
          st_mid = ST_HELD;
        end
      end else begin
        if (cnt_q > {{(CntW-1){1'b0}}, 1'b1}) begin
          if (st_q == ST_HELD) begin
            st_mid  = ST_RELEASED;
            tmr_mid = '0;
          end else if (tmr_q != '0) begin
            st_mid  = ST_DOUBLE;
            tmr_mid = '0;
          end else begin
            tmr_mid = cfg_i.dclick_win;
          end
        end
        cnt_d = '0;
      end
      // window countdown runs after the press or release
      tmr_d = tmr_mid;
      st_d  = st_mid;
      if (tmr_mid != '0) begin
        tmr_d = tmr_mid - {{(TickW-1){1'b0}}, 1'b1};
        if (tmr_d == '0) begin
          st_d = ST_CLICKED;
        end
      end
    end else begin
      if (st_q != ST_HELD) begin
        st_d = ST_OPEN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      tmr_q <= '0;
      st_q  <= ST_OPEN;
    end else if (step_i) begin
      cnt_q <= cnt_d;
      tmr_q <= tmr_d;
      st_q  <= st_d;
    end
  end

  assign status_o = st_q;

endmodule

// ----- rtl/bcc_out_reg.sv -----
// Result register holding one status until the consumer takes it.
// Depends on bcc_pkg.
module bcc_out_reg
  import bcc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  status_e status_i,
  input  logic    out_ready_i,
  output logic    free_o,
  output logic    out_valid_o,
  output logic [2:0] button_status_o
);

  logic    valid_q, valid_d;
  status_e data_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= status_i;
    end
  end

  assign out_valid_o     = valid_q;
  assign button_status_o = data_q;

endmodule

// ----- rtl/button_click_classifier.sv -----
// Top level of the push-button click classifier.
// Depends on bcc_pkg, bcc_state, bcc_out_reg and the assertion macro header.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------
//   in      | input     | in_valid_i / in_ready_o | action_i, pin_level_i
//   out     | output    | out_valid_o/out_ready_i | button_status_o
//   cfg     | input     | cfg_we_i (no wait)      | cfg_idx_i, cfg_wdata_i
//
// One request a cycle unless a read stalls: each lands in the input register,
// and when it advances from there the state update and the result register load
// happen together. A tick in the input register always advances; a read there
// waits while the result register is full and out_ready_i is low, and holds the
// input off behind it. Reset returns state and config to their defaults at once.
`include "button_click_classifier_macros.svh"

module button_click_classifier
  import bcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic       pin_level_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] button_status_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  // Configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_level <= 1'b0;
      cfg_q.hold_lim     <= 8'd100;
      cfg_q.dclick_win   <= 8'd50;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_ACTIVE_LEVEL: cfg_q.active_level <= cfg_wdata_i[0];
        REG_HOLD_LIM:     cfg_q.hold_lim     <= cfg_wdata_i;
        REG_DCLICK_WIN:   cfg_q.dclick_win   <= cfg_wdata_i;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  // Input register
  logic    in_valid_q;
  item_t   item_q;
  logic    out_free;
  logic    advance;
  logic    rd_fire;
  status_e cur_status;

  // Advance the held request unless it is a read facing a full result register
  assign advance    = in_valid_q && ((item_q.action == ACT_TICK) || out_free);
  assign rd_fire    = advance && (item_q.action == ACT_READ);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.action    <= action_e'(action_i);
      item_q.pin_level <= pin_level_i;
    end
  end

  bcc_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .status_o (cur_status)
  );

  // Hold the status seen by a read until the consumer takes it
  bcc_out_reg u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (rd_fire),
    .status_i        (cur_status),
    .out_ready_i     (out_ready_i),
    .free_o          (out_free),
    .out_valid_o     (out_valid_o),
    .button_status_o (button_status_o)
  );

  `BCC_ASSERT_NOW(a_empty_takes, !in_valid_q, in_ready_o)
  `BCC_ASSERT_NOW(a_tick_no_stall, in_valid_q && (item_q.action == ACT_TICK), advance)
  `BCC_ASSERT_NOW(a_result_from_read, $rose(out_valid_o), $past(rd_fire))
  `BCC_ASSERT_NEXT(a_read_gives_result, rd_fire, out_valid_o)

endmodule

// ----- bench/button_click_classifier_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for button_click_classifier: a queue-fed request driver,
// a result monitor and an in-bench status predictor. Depends on bcc_pkg.
module button_click_classifier_tb;
  import bcc_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned MaxGap     = 19;
  localparam int unsigned LongHold   = 240;
  localparam int unsigned SettleCyc  = 4;   // settle time after the last result
  localparam int unsigned MaxPrinted = 50;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic       in_ready_o;
  logic       action_i        = 1'b0;
  logic       pin_level_i     = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i     = 1'b0;
  logic [2:0] button_status_o;
  logic       cfg_we_i        = 1'b0;
  logic [1:0] cfg_idx_i       = '0;
  logic [7:0] cfg_wdata_i     = '0;

  button_click_classifier dut (.*);

  // Bench copy of the configuration, updated as each register write lands.
  logic             cfg_active = 1'b0;
  logic [TickW-1:0] cfg_hold   = 8'd100;
  logic [TickW-1:0] cfg_dclick = 8'd50;

  // Predicted button state.
  logic [CntW-1:0]  btn_pressed_cnt = '0;
  logic [TickW-1:0] btn_window      = '0;
  status_e          btn_status      = ST_OPEN;

  item_t       pending_reqs[$];   // requests not yet offered
  status_e     status_due[$];     // statuses owed by reads already accepted
  int unsigned queued_reqs    = 0;
  int unsigned errors         = 0;
  int unsigned cycles         = 0;
  int unsigned src_max_gap    = MaxGap;
  int unsigned snk_max_gap    = MaxGap;
  bit          want_long_hold = 1'b0;
  bit          long_hold_done = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Give up on a hung block.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("button_click_classifier_tb: done, errors");
      $finish;
    end
  end

  task automatic flag_mismatch(string msg);
    errors++;
    if (errors <= MaxPrinted) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // At least a third of the waits are zero so back-to-back stretches occur in every phase.
  function automatic int unsigned draw_gap(int unsigned max_gap);
    if (max_gap == 0 || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, max_gap);
  endfunction

  // Advance the predicted state by one accepted request.
  task automatic classify_request(item_t req);
    if (req.action == ACT_READ) begin
      status_due.push_back(btn_status);
      if (btn_status != ST_HELD) btn_status = ST_OPEN;
    end else begin
      if (req.pin_level == cfg_active) begin
        // The pressed count saturates rather than wrapping.
        if (btn_pressed_cnt != CntMax) btn_pressed_cnt++;
        if (btn_pressed_cnt > {1'b0, cfg_hold}) btn_status = ST_HELD;
      end else begin
        // Presses of one tick or none are ignored apart from clearing the count.
        if (btn_pressed_cnt > 1) begin
          if (btn_status == ST_HELD) begin
            btn_status = ST_RELEASED;
            btn_window = '0;
          end else if (btn_window != 0) begin
            btn_status = ST_DOUBLE;
            btn_window = '0;
          end else begin
            btn_window = cfg_dclick;
          end
        end
        btn_pressed_cnt = '0;
      end
      // A window opened on this tick already counts down on this tick.
      if (btn_window != 0) begin
        btn_window--;
        if (btn_window == 0) btn_status = ST_CLICKED;
      end
    end
  endtask

  // Request driver: hold a request until accepted, then wait a drawn gap.
  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    item_t       on_offer;
    int unsigned src_wait;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      action_i    <= ACT_TICK;
      pin_level_i <= 1'b0;
      src_wait    = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        classify_request(on_offer);
        src_wait = draw_gap(src_max_gap);
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (src_wait != 0 || pending_reqs.size() == 0) begin
          in_valid_i <= 1'b0;
          if (src_wait != 0) src_wait--;
        end else begin
          on_offer    = pending_reqs.pop_front();
          in_valid_i  <= 1'b1;
          action_i    <= on_offer.action;
          pin_level_i <= on_offer.pin_level;
        end
      end
    end
  end

  // Result monitor: check each accepted status, then drop ready for a drawn gap.
  always @(posedge clk_i or negedge rst_ni) begin : status_monitor
    status_e     want;
    int unsigned snk_wait;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      snk_wait    = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (status_due.size() == 0) begin
          flag_mismatch($sformatf("status %0d with no read outstanding", button_status_o));
        end else begin
          want = status_due.pop_front();
          if (button_status_o !== want)
            flag_mismatch($sformatf("status %0d, predicted %0d", button_status_o, want));
        end
        snk_wait = draw_gap(snk_max_gap);
        // Once, hold off long enough for reads to back up into the input.
        if (want_long_hold && !long_hold_done) begin
          snk_wait       = LongHold;
          long_hold_done = 1'b1;
        end
      end
      if (snk_wait != 0) begin
        out_ready_i <= 1'b0;
        snk_wait--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic push_request(action_e act, logic lvl);
    item_t req;
    req.action    = act;
    req.pin_level = lvl;
    pending_reqs.push_back(req);
    queued_reqs++;
  endtask

  task automatic push_ticks(logic lvl, int unsigned n);
    repeat (n) push_request(ACT_TICK, lvl);
  endtask

  task automatic push_read();
    push_request(ACT_READ, 1'b0);
  endtask

  // Wait until every request is taken and every read answered, then settle.
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || status_due.size() != 0);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // Write all three registers; call only while the block is quiet.
  task automatic set_config(logic act_lvl, logic [7:0] hold, logic [7:0] dclick);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_ACTIVE_LEVEL;
    cfg_wdata_i <= {7'd0, act_lvl};
    cfg_active  = act_lvl;
    @(posedge clk_i);
    cfg_idx_i   <= REG_HOLD_LIM;
    cfg_wdata_i <= hold;
    cfg_hold    = hold;
    @(posedge clk_i);
    cfg_idx_i   <= REG_DCLICK_WIN;
    cfg_wdata_i <= dclick;
    cfg_dclick  = dclick;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // One press-and-release with random lengths, reads scattered through it.
  // Short releases let the next press land inside the window as a double click.
  task automatic queue_gesture();
    int unsigned sel, press_n, hi;
    hi  = (cfg_hold < 2) ? 2 : cfg_hold;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      repeat ($urandom_range(1, 4))
        push_request(action_e'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else begin
      if (sel <= 2)      press_n = $urandom_range(0, 1);
      else if (sel <= 6) press_n = $urandom_range(2, hi);
      else               press_n = cfg_hold + $urandom_range(1, 3);
      push_ticks(cfg_active, press_n);
      if ($urandom_range(0, 3) == 0) push_read();
      push_ticks(!cfg_active, $urandom_range(1, cfg_dclick + 2));
      if ($urandom_range(0, 1) == 0) push_read();
    end
  endtask

  task automatic queue_gestures(int unsigned n_reqs);
    int unsigned start;
    start = queued_reqs;
    while (queued_reqs - start < n_reqs) queue_gesture();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: pressed level low, hold beyond three ticks, window of four.
    set_config(1'b0, 8'd3, 8'd4);
    push_read();                      // open after reset
    push_ticks(1'b0, 1);              // a one-tick press is ignored
    push_ticks(1'b1, 1);
    push_read();
    push_ticks(1'b0, 2);              // click: window opens, then runs out
    push_ticks(1'b1, 4);
    push_read();
    push_read();                      // a read clears clicked back to open
    push_ticks(1'b0, 2);              // second press inside the window
    push_ticks(1'b1, 1);
    push_ticks(1'b0, 2);
    push_ticks(1'b1, 1);
    push_read();
    push_ticks(1'b0, 5);              // long press becomes held
    push_read();
    push_read();                      // held survives a read
    push_ticks(1'b1, 1);
    push_read();                      // released after the hold
    wait_quiet();

    // Random, pressed level high; pause midway until all reads are answered.
    set_config(1'b1, 8'd6, 8'd5);
    queue_gestures(50);
    wait_quiet();
    queue_gestures(50);
    wait_quiet();

    // Back-to-back requests against one long stall of the result side.
    src_max_gap    = 0;
    want_long_hold = 1'b1;
    set_config(1'b0, 8'd2, 8'd3);
    queue_gestures(100);
    wait_quiet();
    src_max_gap = MaxGap;

    // Zero-length window and immediate hold.
    set_config(1'b1, 8'd0, 8'd0);
    queue_gestures(40);
    wait_quiet();

    // One-tick window: it opens and runs out on the same tick.
    snk_max_gap = 0;
    set_config(1'b1, 8'd1, 8'd1);
    queue_gestures(50);
    wait_quiet();
    snk_max_gap = MaxGap;

    // Longer limits to finish.
    set_config(1'b0, 8'd20, 8'd12);
    queue_gestures(50);
    wait_quiet();

    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("button_click_classifier_tb: done, clean");
    end else begin
      $display("button_click_classifier_tb: done, errors");
    end
    $finish;
  end

endmodule
